[design/lkvc_pkg.sv]
// Shared types and constants for the LRU key-value cache.
`default_nettype none
package lkvc_pkg;
  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam int unsigned CAP_W = 5;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;
  localparam int unsigned ADDR_CAPACITY = 0;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

[design/lkvc_ram.sv]
// Generic single-port-write RAM with a registered read port.
`default_nettype none
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/lru_key_value_cache_core.sv]
// Top level of the LRU key-value cache.
`default_nettype none
// Fully associative key-value store with least-recently-used replacement. Each
// input beat carries a get or a set; a get yields one output beat (hit and
// value, or hit=0 and all ones on a miss), a set yields none. In the lookup
// state the key is matched against all entries, the per-entry recency ranks and
// valid bits held in flip-flops are updated and the registered value RAM read is
// issued; in the output state the result goes to the output register, which may
// wait there. Keys live in flip-flops so every entry can be compared at once; values
// live in a synchronous RAM. The capacity register (address 0) sets how many
// entries fill before eviction starts; it resets to 16 and is clamped to 1..ENTRIES.
module lru_key_value_cache_core #(
  parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: [31:0] key, [63:32] value; tuser: op
  input  wire logic [63:0] s_tdata,
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: [31:0] read_value; tuser: hit
  output logic      [31:0] m_tdata,
  output logic             m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [lkvc_pkg::CAP_W-1:0] capacity;
  logic [lkvc_pkg::KEY_W-1:0] keys [ENTRIES];
  logic [ENTRIES-1:0]         valid;
  logic [IW-1:0]              rank [ENTRIES];
  logic [CW-1:0]              occupied;
  lkvc_pkg::state_t           state, state_next;
  logic [lkvc_pkg::KEY_W-1:0] in_key;
  logic [lkvc_pkg::VAL_W-1:0] in_val;
  logic                       in_op;
  logic                       hit_r;
  logic                       out_full;

  // APB register access.
  assign pready = 1'b1;
  assign prdata = (paddr == 3'(lkvc_pkg::ADDR_CAPACITY * 4)) ? 32'(capacity) : '0;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == 3'(lkvc_pkg::ADDR_CAPACITY * 4)) begin
      capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  // Effective capacity, clamped to 1..ENTRIES.
  logic [CW:0] eff_cap;
  always_comb begin
    if (capacity == '0) begin
      eff_cap = (CW+1)'(1);
    end else if (32'(capacity) > ENTRIES) begin
      eff_cap = (CW+1)'(ENTRIES);
    end else begin
      eff_cap = (CW+1)'(capacity);
    end
  end

  // Parallel key match, LRU victim and free slot search.
  logic [ENTRIES-1:0] match;
  logic               found;
  logic [IW-1:0]      hit_idx, lru_idx, free_idx;
  logic               do_evict;
  logic [IW-1:0]      ins_idx;
  always_comb begin
    found = 1'b0;
    hit_idx = '0;
    lru_idx = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid[i] && keys[i] == in_key;
      if (match[i]) begin
        found = 1'b1;
        hit_idx = IW'(i);
      end
      if (valid[i] && CW'(rank[i]) == occupied - CW'(1)) begin
        lru_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_idx = IW'(i);
      end
    end
    do_evict = (CW+1)'(occupied) >= eff_cap && occupied != '0;
    ins_idx = do_evict ? lru_idx : free_idx;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      lkvc_pkg::ST_IDLE:   if (s_tvalid) state_next = lkvc_pkg::ST_LOOKUP;
      lkvc_pkg::ST_LOOKUP: state_next = lkvc_pkg::ST_OUT;
      lkvc_pkg::ST_OUT:    if (in_op == lkvc_pkg::OP_SET || !out_full)
                             state_next = lkvc_pkg::ST_IDLE;
      default:             state_next = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = state == lkvc_pkg::ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_key <= s_tdata[31:0];
      in_val <= s_tdata[63:32];
      in_op  <= s_tuser;
    end
  end

  // Key, valid and recency update in the lookup cycle.
  logic          lookup;
  logic [IW-1:0] tgt;
  assign lookup = state == lkvc_pkg::ST_LOOKUP;
  assign tgt = found ? hit_idx : ins_idx;
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occupied <= '0;
      for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
    end else if (lookup) begin
      if (found) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && rank[i] < rank[hit_idx]) rank[i] <= rank[i] + IW'(1);
        end
        rank[hit_idx] <= '0;
      end else if (in_op == lkvc_pkg::OP_SET) begin
        // Evicted slot is reused, so occupancy is unchanged on eviction.
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && !(do_evict && IW'(i) == lru_idx)) rank[i] <= rank[i] + IW'(1);
        end
        rank[ins_idx] <= '0;
        valid[ins_idx] <= 1'b1;
        if (!do_evict) occupied <= occupied + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup && !found && in_op == lkvc_pkg::OP_SET) begin
      keys[ins_idx] <= in_key;
    end
    if (lookup) hit_r <= found;
  end

  // Value memory: written by sets, read for gets.
  logic [lkvc_pkg::VAL_W-1:0] rd_val;
  lkvc_ram #(.WIDTH(lkvc_pkg::VAL_W), .DEPTH(ENTRIES)) u_values (
    .clk  (clk),
    .we   (lookup && in_op == lkvc_pkg::OP_SET),
    .waddr(tgt),
    .wdata(in_val),
    .raddr(hit_idx),
    .rdata(rd_val)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (state == lkvc_pkg::ST_OUT && in_op == lkvc_pkg::OP_GET && !out_full) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (state == lkvc_pkg::ST_OUT && in_op == lkvc_pkg::OP_GET && !out_full) begin
      m_tuser <= hit_r;
      m_tdata <= hit_r ? rd_val : lkvc_pkg::MISS_VALUE;
    end
  end
  assign m_tvalid = out_full;

  // Checks.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occupied) <= ENTRIES) else $error("occupancy exceeds entries");
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(occupied)) else $error("valid count mismatch");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    lookup |=> !s_tready) else $error("accepted during work");
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == lkvc_pkg::MISS_VALUE) else $error("miss value");
endmodule
`default_nettype wire
